/* src/mcd_pkg.sv */
`default_nettype none

package mcd_pkg;

    // Memory geometry.
    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Request codes of an input beat.
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_START = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    // Processor control states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_F0   = 3'd1,
        ST_F1   = 3'd2,
        ST_D0   = 3'd3,
        ST_D1   = 3'd4,
        ST_E0   = 3'd5,
        ST_E1   = 3'd6
    } t_cst;

    // Copy engine states.
    typedef enum logic [1:0] {
        CP_IDLE  = 2'd0,
        CP_WAIT  = 2'd1,
        CP_READ  = 2'd2,
        CP_WRITE = 2'd3
    } t_dma;

    // Beat handling phases.
    typedef enum logic [1:0] {
        P_IDLE = 2'd0,
        P_EXEC = 2'd1,
        P_DONE = 2'd2
    } t_phase;

    // Opcodes.
    localparam logic [4:0] OP_ADD = 5'd0;
    localparam logic [4:0] OP_SUB = 5'd1;
    localparam logic [4:0] OP_LSF = 5'd2;
    localparam logic [4:0] OP_RSF = 5'd3;
    localparam logic [4:0] OP_AND = 5'd4;
    localparam logic [4:0] OP_OR  = 5'd5;
    localparam logic [4:0] OP_XOR = 5'd6;
    localparam logic [4:0] OP_LHI = 5'd7;
    localparam logic [4:0] OP_LD  = 5'd8;
    localparam logic [4:0] OP_ST  = 5'd9;
    localparam logic [4:0] OP_JLT = 5'd16;
    localparam logic [4:0] OP_JLE = 5'd17;
    localparam logic [4:0] OP_JEQ = 5'd18;
    localparam logic [4:0] OP_JNE = 5'd19;
    localparam logic [4:0] OP_JIN = 5'd20;
    localparam logic [4:0] OP_HLT = 5'd24;
    localparam logic [4:0] OP_CPY = 5'd25;
    localparam logic [4:0] OP_CPO = 5'd26;

    // Link register index.
    localparam logic [2:0] LINK_REG = 3'd7;

    typedef struct packed {
        t_req        req_type;
        logic [15:0] addr;
        logic [31:0] wdata;
    } t_in;

    typedef struct packed {
        logic [31:0] rdata;
        logic [15:0] prog_counter;
        logic [2:0]  control_state;
        logic        copy_busy;
        logic        halted;
        logic [31:0] cycles;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_load;
        logic host_wr;
        logic host_rd;
        logic run_set;
        logic tick;
        logic pc_clear;
        logic fetch_rd;
        logic ir_load;
        logic decode;
        logic opnd_load;
        logic cpy_load;
        logic req_clear;
        logic alu_en;
        logic retire;
        logic run_clr;
        logic dma_rd;
        logic dma_wr;
        logic out_load;
        logic copy_busy;
        logic halted;
        t_cst cst;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [4:0] opcode;
        logic       run_flag;
        logic       copy_request;
        logic       copy_last;
    } t_sts;

endpackage

`default_nettype wire

/* src/mcd_ctrl.sv */
`default_nettype none

module mcd_ctrl
    import mcd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  t_req i_req,
    input  wire  i_out_stall,
    input  t_sts i_sts,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_phase r_phase, n_phase;
    t_req   r_req, n_req;
    t_cst   r_cst, n_cst;
    t_dma   r_dst, n_dst;
    logic   r_halt_seen, n_halt_seen;
    logic   r_out_valid, n_out_valid;

    logic w_tick, w_accept, w_out_load, w_dma_on, w_avail, w_cpy_start, w_go;

    // Handshake and shared decode terms.
    always_comb begin
        w_tick      = (r_phase == P_EXEC) && (r_req == REQ_TICK);
        w_accept    = i_in_valid && (r_phase == P_IDLE);
        w_out_load  = (r_phase == P_DONE) && (!r_out_valid || !i_out_stall);
        w_dma_on    = w_tick && (r_cst != ST_IDLE);
        w_avail     = (r_cst == ST_F1) ||
                      ((r_cst == ST_D1) && (i_sts.opcode != OP_LD) &&
                       (i_sts.opcode != OP_ST));
        w_cpy_start = (r_cst == ST_D1) && (i_sts.opcode == OP_CPY) && (r_dst == CP_IDLE);
        w_go        = (r_cst != ST_E0) && (i_sts.copy_request || w_cpy_start);
    end

    // Next state.
    always_comb begin
        n_phase     = r_phase;
        n_req       = r_req;
        n_cst       = r_cst;
        n_dst       = r_dst;
        n_halt_seen = r_halt_seen;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_phase)
            P_IDLE: begin
                if (w_accept) begin
                    n_phase = P_EXEC;
                    n_req   = i_req;
                end
            end
            P_EXEC: begin
                n_phase = P_DONE;
            end
            P_DONE: begin
                if (w_out_load) begin
                    n_phase     = P_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
        if (w_tick) begin
            case (r_cst)
                ST_IDLE: begin
                    if (i_sts.run_flag) begin
                        n_cst       = ST_F0;
                        n_halt_seen = 1'b0;
                    end
                end
                ST_F0: n_cst = ST_F1;
                ST_F1: n_cst = ST_D0;
                ST_D0: n_cst = ST_D1;
                ST_D1: n_cst = ST_E0;
                ST_E0: n_cst = ST_E1;
                ST_E1: begin
                    if (i_sts.opcode == OP_HLT) begin
                        n_cst       = ST_IDLE;
                        n_halt_seen = 1'b1;
                    end else begin
                        n_cst = ST_F0;
                    end
                end
                default: n_cst = ST_IDLE;
            endcase
        end
        if (w_dma_on) begin
            case (r_dst)
                CP_IDLE:  n_dst = w_go ? CP_WAIT : CP_IDLE;
                CP_WAIT:  n_dst = w_avail ? CP_READ : CP_WAIT;
                CP_READ:  n_dst = CP_WRITE;
                CP_WRITE: begin
                    if (i_sts.copy_last) begin
                        n_dst = CP_IDLE;
                    end else begin
                        n_dst = w_avail ? CP_READ : CP_WAIT;
                    end
                end
                default:  n_dst = CP_IDLE;
            endcase
        end
    end

    // Commands.
    always_comb begin
        o_in_stall          = (r_phase != P_IDLE);
        o_out_valid         = r_out_valid;
        o_cmd.in_load       = w_accept;
        o_cmd.host_wr       = (r_phase == P_EXEC) && (r_req == REQ_WRITE);
        o_cmd.host_rd       = (r_phase == P_EXEC) && (r_req == REQ_READ);
        o_cmd.run_set       = (r_phase == P_EXEC) && (r_req == REQ_START);
        o_cmd.tick          = w_tick;
        o_cmd.pc_clear      = w_tick && (r_cst == ST_IDLE);
        o_cmd.fetch_rd      = w_tick && (r_cst == ST_F0);
        o_cmd.ir_load       = w_tick && (r_cst == ST_F1);
        o_cmd.decode        = w_tick && (r_cst == ST_D0);
        o_cmd.opnd_load     = w_tick && (r_cst == ST_D1);
        o_cmd.cpy_load      = w_tick && w_cpy_start;
        o_cmd.req_clear     = w_tick && (r_cst == ST_E0);
        o_cmd.alu_en        = w_tick && (r_cst == ST_E0);
        o_cmd.retire        = w_tick && (r_cst == ST_E1) && (i_sts.opcode != OP_HLT);
        o_cmd.run_clr       = w_tick && (r_cst == ST_E1) && (i_sts.opcode == OP_HLT);
        o_cmd.dma_rd        = w_dma_on && (r_dst == CP_READ);
        o_cmd.dma_wr        = w_dma_on && (r_dst == CP_WRITE);
        o_cmd.out_load      = w_out_load;
        o_cmd.copy_busy     = (r_dst != CP_IDLE);
        o_cmd.halted        = r_halt_seen && (r_cst == ST_IDLE);
        o_cmd.cst           = r_cst;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_req       <= REQ_WRITE;
            r_cst       <= ST_IDLE;
            r_dst       <= CP_IDLE;
            r_halt_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_req       <= n_req;
            r_cst       <= n_cst;
            r_dst       <= n_dst;
            r_halt_seen <= n_halt_seen;
            r_out_valid <= n_out_valid;
        end
    end

    // An accepted beat is executed in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_phase == P_EXEC))
        else $error("accepted beat not executed");

    // A tick in E0 moves the control state on to E1.
    a_e0_e1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick && (r_cst == ST_E0)) |=> (r_cst == ST_E1))
        else $error("execute sequence broken");

    // A copy read is always followed by its write.
    a_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick && (r_cst != ST_IDLE) && (r_dst == CP_READ)) |=> (r_dst == CP_WRITE))
        else $error("copy read without write");

    // A held result stays while stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire

/* src/mcd_dp.sv */
`default_nettype none

module mcd_dp
    import mcd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_in  i_in_data,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_out_data
);

    logic [31:0] r_rf [8];
    logic [15:0] r_pc;
    logic [31:0] r_ir, r_opa, r_opb, r_alu, r_imm, r_cycles;
    logic [4:0]  r_op;
    logic [2:0]  r_dest, r_srca, r_srcb;
    logic [31:0] r_len, r_done, r_src, r_dstw;
    logic        r_creq, r_run, r_tick_rd;
    logic [31:0] r_mem_out, r_rd_data;
    t_in         r_in;
    t_out        r_out;
    logic [31:0] mem [MEM_DEPTH];

    logic              w_we, w_re;
    logic [MEM_AW-1:0] w_ma;
    logic [31:0]       w_md, w_opa, w_opb, w_alu;
    logic [4:0]        w_sh;
    logic              w_jump;

    // Memory port selection: host, then processor, then copy engine.
    always_comb begin
        w_we = 1'b0;
        w_re = 1'b0;
        w_ma = i_in_data.addr[MEM_AW-1:0];
        w_md = r_in.wdata;
        if (i_cmd.host_wr) begin
            w_we = 1'b1;
            w_ma = r_in.addr[MEM_AW-1:0];
        end else if (i_cmd.host_rd) begin
            w_re = 1'b1;
            w_ma = r_in.addr[MEM_AW-1:0];
        end else if (i_cmd.fetch_rd) begin
            w_re = 1'b1;
            w_ma = r_pc[MEM_AW-1:0];
        end else if (i_cmd.alu_en && (r_op == OP_LD)) begin
            w_re = 1'b1;
            w_ma = r_opb[MEM_AW-1:0];
        end else if (i_cmd.retire && (r_op == OP_ST)) begin
            w_we = 1'b1;
            w_ma = r_opb[MEM_AW-1:0];
            w_md = r_opa;
        end else if (i_cmd.dma_rd) begin
            w_re = 1'b1;
            w_ma = r_src[MEM_AW-1:0];
        end else if (i_cmd.dma_wr) begin
            w_we = 1'b1;
            w_ma = r_dstw[MEM_AW-1:0];
            w_md = r_mem_out;
        end
    end

    // Operand selection: index 0 is zero, index 1 the immediate.
    always_comb begin
        case (r_srca)
            3'd0:    w_opa = '0;
            3'd1:    w_opa = r_imm;
            default: w_opa = r_rf[r_srca];
        endcase
        case (r_srcb)
            3'd0:    w_opb = '0;
            3'd1:    w_opb = r_imm;
            default: w_opb = r_rf[r_srcb];
        endcase
    end

    // ALU.
    always_comb begin
        w_sh  = r_opa[4:0];
        w_alu = r_alu;
        case (r_op)
            OP_CPO: w_alu = {31'b0, i_cmd.copy_busy};
            OP_ADD: w_alu = r_opa + r_opb;
            OP_SUB: w_alu = r_opa - r_opb;
            OP_LSF: w_alu = r_opb << w_sh;
            OP_RSF: w_alu = $signed(r_opb) >>> w_sh;
            OP_AND: w_alu = r_opa & r_opb;
            OP_OR:  w_alu = r_opa | r_opb;
            OP_XOR: w_alu = r_opa ^ r_opb;
            OP_LHI: w_alu = {r_opb[15:0], r_opa[15:0]};
            OP_JLT: w_alu = {31'b0, $signed(r_opa) < $signed(r_opb)};
            OP_JLE: w_alu = {31'b0, $signed(r_opa) <= $signed(r_opb)};
            OP_JEQ: w_alu = {31'b0, r_opa == r_opb};
            OP_JNE: w_alu = {31'b0, r_opa != r_opb};
            OP_JIN: w_alu = 32'd1;
            OP_ST:  w_alu = '0;
            OP_HLT: w_alu = '0;
            default: w_alu = r_alu;
        endcase
        w_jump = (r_op >= OP_JLT) && (r_op <= OP_JIN);
    end

    // Status toward the controller.
    always_comb begin
        o_sts.opcode       = r_op;
        o_sts.run_flag     = r_run;
        o_sts.copy_request = r_creq;
        o_sts.copy_last    = (r_done == (r_len - 32'd1));
        o_out_data         = r_out;
    end

    // Memory array with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_ma] <= w_md;
        end
        if (w_re) begin
            r_rd_data <= mem[w_ma];
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.out_load) begin
            r_out.rdata         <= (r_in.req_type == REQ_READ) ? r_rd_data : '0;
            r_out.prog_counter  <= r_pc;
            r_out.control_state <= i_cmd.cst;
            r_out.copy_busy     <= i_cmd.copy_busy;
            r_out.halted        <= i_cmd.halted;
            r_out.cycles        <= r_cycles;
        end
    end

    // Architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) begin
                r_rf[k] <= '0;
            end
            r_pc      <= '0;
            r_ir      <= '0;
            r_op      <= '0;
            r_dest    <= '0;
            r_srca    <= '0;
            r_srcb    <= '0;
            r_opa     <= '0;
            r_opb     <= '0;
            r_alu     <= '0;
            r_imm     <= '0;
            r_cycles  <= '0;
            r_len     <= '0;
            r_done    <= '0;
            r_src     <= '0;
            r_dstw    <= '0;
            r_creq    <= 1'b0;
            r_run     <= 1'b0;
            r_mem_out <= '0;
            r_tick_rd <= 1'b0;
        end else begin
            if (i_cmd.run_set) begin
                r_run <= 1'b1;
            end
            if (i_cmd.tick) begin
                r_cycles  <= r_cycles + 32'd1;
                r_tick_rd <= i_cmd.fetch_rd || i_cmd.dma_rd ||
                             (i_cmd.alu_en && (r_op == OP_LD));
            end else if (i_cmd.out_load) begin
                r_tick_rd <= 1'b0;
            end
            // Tick reads land in the memory output register.
            if (i_cmd.out_load && r_tick_rd) begin
                r_mem_out <= r_rd_data;
            end
            if (i_cmd.pc_clear) begin
                r_pc <= '0;
            end
            if (i_cmd.ir_load) begin
                r_ir <= r_mem_out;
            end
            if (i_cmd.decode) begin
                r_op   <= r_ir[29:25];
                r_dest <= r_ir[24:22];
                r_srca <= r_ir[21:19];
                r_srcb <= r_ir[18:16];
                r_imm  <= {{16{r_ir[15]}}, r_ir[15:0]};
            end
            if (i_cmd.opnd_load) begin
                if (r_op == OP_LHI) begin
                    r_opa <= r_rf[r_dest];
                    r_opb <= r_imm;
                end else begin
                    r_opa <= w_opa;
                    r_opb <= w_opb;
                end
            end
            if (i_cmd.cpy_load) begin
                r_creq <= 1'b1;
                r_src  <= r_rf[r_srca];
                r_dstw <= r_rf[r_srcb];
                r_len  <= r_imm;
            end
            if (i_cmd.req_clear) begin
                r_creq <= 1'b0;
            end
            if (i_cmd.alu_en) begin
                r_alu <= w_alu;
            end
            if (i_cmd.run_clr) begin
                r_run <= 1'b0;
            end
            // Copy engine counters advance on each write beat.
            if (i_cmd.dma_wr) begin
                r_src  <= r_src + 32'd1;
                r_dstw <= r_dstw + 32'd1;
                r_done <= o_sts.copy_last ? '0 : (r_done + 32'd1);
            end
            // Retire: write back or branch.
            if (i_cmd.retire) begin
                if (w_jump && (r_alu == 32'd1)) begin
                    r_pc           <= r_ir[15:0];
                    r_rf[LINK_REG] <= {16'b0, r_pc};
                end else begin
                    r_pc <= r_pc + 16'd1;
                    if (r_op == OP_LD) begin
                        r_rf[r_dest] <= r_mem_out;
                    end else if (!w_jump && r_op != OP_ST &&
                                 (r_op <= OP_LHI || r_op == OP_CPO)) begin
                        r_rf[r_dest] <= r_alu;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* src/multicycle_cpu_with_dma_core.sv */
`default_nettype none

// Channel   Valid        Stall         Payload
// input     i_in_valid   o_in_stall    i_in_data  (t_in)
// output    o_out_valid  i_out_stall   o_out_data (t_out)
//
// Every input beat is accepted, then executed (a memory access or one
// processor clock), and then loaded into the result register.
// The single-port SRAM with its registered read sets this sequence.
// Reset is synchronous and active low; the SRAM contents are not cleared.
// A new beat is taken while a finished result still waits under stall; its
// own result then waits until the earlier one has left.
module multicycle_cpu_with_dma_core
    import mcd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_out o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Controller.
    mcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req       (i_in_data.req_type),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // Datapath with registers, ALU and SRAM.
    mcd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

/* test/tb_multicycle_cpu_with_dma_core.sv */
`default_nettype none

module tb_multicycle_cpu_with_dma_core;
    import mcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 20000;

    // Data window for loads, stores and copies; programs sit below it.
    localparam int         DATA_LO  = 64;
    localparam int         DATA_HI  = 127;
    localparam logic [2:0] COPY_REG = 3'd2;

    // Architectural state of the processor and its copy engine.
    typedef struct {
        logic [31:0] rf [8];
        logic [15:0] pc;
        logic [31:0] ir;
        logic [4:0]  opc;
        logic [2:0]  dst, sa, sb;
        logic [31:0] opa, opb, alu, imm, cyc;
        t_cst        cst;
        t_dma        cps;
        logic [31:0] clen, cdone, csrc, cdst, mout;
        logic        cbusy, creq, run, hseen;
    } t_cpu;

    typedef struct {
        t_in  d;
        bit   typed;
        t_out want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in         i_in_data = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out_data;

    t_cpu        cpu;
    logic [31:0] mem_img [0:65535];
    t_out        want_q [$];
    int          cyc_n = 0;
    int          errors = 0;
    bit          quiet;

    multicycle_cpu_with_dma_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // A window of the run with no idling on either side.
    assign quiet = (cyc_n >= 300) && (cyc_n < 700);

    // Operand fetch: index 0 is zero, index 1 is the immediate.
    function automatic logic [31:0] opnd(input t_cpu o, input logic [2:0] idx);
        if (idx == 3'd0) return 32'd0;
        if (idx == 3'd1) return o.imm;
        return o.rf[idx];
    endfunction

    // One clock of the copy engine; it moves a word per read/write pair.
    function automatic void copy_clock(input t_cpu o, inout t_cpu n, input bit avail,
                                       input bit go, inout bit rd, inout logic [15:0] rda,
                                       inout bit wr, inout logic [15:0] wra,
                                       inout logic [31:0] wrd);
        case (o.cps)
            CP_IDLE: begin
                if (go) begin
                    n.cps = CP_WAIT;
                    n.cbusy = 1'b1;
                end
            end
            CP_WAIT: n.cps = avail ? CP_READ : CP_WAIT;
            CP_READ: begin
                rd = 1'b1;
                rda = o.csrc[15:0];
                n.cps = CP_WRITE;
            end
            default: begin
                wr = 1'b1;
                wra = o.cdst[15:0];
                wrd = o.mout;
                n.cdone = o.cdone + 1;
                n.cdst = o.cdst + 1;
                n.csrc = o.csrc + 1;
                if (o.cdone == o.clen - 1) begin
                    n.cbusy = 1'b0;
                    n.cps = CP_IDLE;
                    n.cdone = 32'd0;
                end else begin
                    n.cps = avail ? CP_READ : CP_WAIT;
                end
            end
        endcase
    endfunction

    // One processor clock.
    function automatic void cpu_clock();
        t_cpu        o;
        bit          rd, wr, go;
        logic [15:0] rda, wra;
        logic [31:0] wrd, a, b;
        logic [4:0]  op;
        logic [4:0]  sh;
        o = cpu;
        rd = 0; wr = 0; rda = '0; wra = '0; wrd = '0;
        op = o.opc; a = o.opa; b = o.opb; sh = a[4:0];
        cpu.cyc = o.cyc + 1;
        case (o.cst)
            ST_IDLE: begin
                cpu.pc = '0;
                if (o.run) begin
                    cpu.cst = ST_F0;
                    cpu.hseen = 1'b0;
                end
            end
            ST_F0: begin
                copy_clock(o, cpu, 1'b0, o.creq, rd, rda, wr, wra, wrd);
                rd = 1'b1;
                rda = o.pc;
                cpu.cst = ST_F1;
            end
            ST_F1: begin
                copy_clock(o, cpu, 1'b1, o.creq, rd, rda, wr, wra, wrd);
                cpu.ir = o.mout;
                cpu.cst = ST_D0;
            end
            ST_D0: begin
                cpu.opc = o.ir[29:25];
                cpu.dst = o.ir[24:22];
                cpu.sa = o.ir[21:19];
                cpu.sb = o.ir[18:16];
                cpu.imm = {{16{o.ir[15]}}, o.ir[15:0]};
                copy_clock(o, cpu, 1'b0, o.creq, rd, rda, wr, wra, wrd);
                cpu.cst = ST_D1;
            end
            ST_D1: begin
                go = o.creq;
                if (op == OP_CPY && !o.cbusy) begin
                    go = 1'b1;
                    cpu.creq = 1'b1;
                    cpu.csrc = o.rf[o.sa];
                    cpu.cdst = o.rf[o.sb];
                    cpu.clen = o.imm;
                end
                copy_clock(o, cpu, op != OP_LD && op != OP_ST, go, rd, rda, wr, wra, wrd);
                if (op == OP_LHI) begin
                    cpu.opa = o.rf[o.dst];
                    cpu.opb = o.imm;
                end else begin
                    cpu.opa = opnd(o, o.sa);
                    cpu.opb = opnd(o, o.sb);
                end
                cpu.cst = ST_E0;
            end
            ST_E0: begin
                cpu.creq = 1'b0;
                copy_clock(o, cpu, 1'b0, 1'b0, rd, rda, wr, wra, wrd);
                case (op)
                    OP_CPO: cpu.alu = {31'd0, o.cbusy};
                    OP_ADD: cpu.alu = a + b;
                    OP_SUB: cpu.alu = a - b;
                    OP_LSF: cpu.alu = b << sh;
                    OP_RSF: cpu.alu = $signed(b) >>> sh;
                    OP_AND: cpu.alu = a & b;
                    OP_OR:  cpu.alu = a | b;
                    OP_XOR: cpu.alu = a ^ b;
                    OP_LHI: cpu.alu = (a & 32'hFFFF) + (b << 16);
                    OP_LD: begin
                        rd = 1'b1;
                        rda = b[15:0];
                    end
                    OP_JLT: cpu.alu = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    OP_JLE: cpu.alu = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
                    OP_JEQ: cpu.alu = (a == b) ? 32'd1 : 32'd0;
                    OP_JNE: cpu.alu = (a != b) ? 32'd1 : 32'd0;
                    OP_JIN: cpu.alu = 32'd1;
                    OP_ST, OP_HLT: cpu.alu = 32'd0;
                    default: ;
                endcase
                cpu.cst = ST_E1;
            end
            default: begin
                copy_clock(o, cpu, 1'b0, o.creq, rd, rda, wr, wra, wrd);
                if (op == OP_HLT) begin
                    cpu.run = 1'b0;
                    cpu.hseen = 1'b1;
                    cpu.cst = ST_IDLE;
                end else begin
                    cpu.cst = ST_F0;
                    cpu.pc = o.pc + 1;
                    if (op == OP_LD) begin
                        cpu.rf[o.dst] = o.mout;
                    end else if (op == OP_ST) begin
                        wr = 1'b1;
                        wra = b[15:0];
                        wrd = a;
                    end else if (op >= OP_JLT && op <= OP_JIN) begin
                        // A taken jump links the old PC into the link register.
                        if (o.alu == 32'd1) begin
                            cpu.pc = o.imm[15:0];
                            cpu.rf[LINK_REG] = {16'd0, o.pc};
                        end
                    end else if (op <= OP_LHI || op == OP_CPO) begin
                        cpu.rf[o.dst] = o.alu;
                    end
                end
            end
        endcase
        // The read sees the word before any write of the same clock.
        if (rd) cpu.mout = mem_img[rda];
        if (wr) mem_img[wra] = wrd;
    endfunction

    function automatic t_out machine_status(input t_in d);
        t_out r;
        r.rdata = '0;
        case (d.req_type)
            REQ_WRITE: mem_img[d.addr] = d.wdata;
            REQ_READ:  r.rdata = mem_img[d.addr];
            REQ_START: cpu.run = 1'b1;
            default:   cpu_clock();
        endcase
        r.prog_counter = cpu.pc;
        r.control_state = cpu.cst;
        r.copy_busy = cpu.cbusy;
        r.halted = cpu.hseen && cpu.cst == ST_IDLE;
        r.cycles = cpu.cyc;
        return r;
    endfunction

    // Queue the expected status and drive one beat until it is taken.
    task automatic send_beat(input t_in d, input bit typed, input t_out want);
        t_out p;
        p = machine_status(d);
        want_q.push_back(typed ? want : p);
        while (!quiet && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send(input t_req rq, input logic [15:0] ad, input logic [31:0] wd);
        send_beat('{req_type: rq, addr: ad, wdata: wd}, 1'b0, '0);
    endtask

    function automatic logic [31:0] encode(input logic [4:0] op, input int pc, input int hlt_at);
        logic [31:0] w;
        w = $urandom;
        w[31:30] = '0;
        w[29:25] = op;
        // Results never land in r0 to r2, so the copy base in r2 stays put.
        w[24:22] = 3'($urandom_range(7, 3));
        if (op >= OP_JLT && op <= OP_JIN) begin
            // Forward targets only, so every program reaches its halt.
            w[15:0] = 16'($urandom_range(hlt_at, pc + 1));
        end else if (op == OP_CPY) begin
            // Copies run in place inside the data window.
            w[21:19] = COPY_REG;
            w[18:16] = COPY_REG;
            w[15:0]  = 16'($urandom_range(8, 1));
        end else if (op == OP_LD || op == OP_ST) begin
            w[18:16] = 3'd1;
            w[15:0]  = 16'($urandom_range(DATA_HI, DATA_LO));
        end
        return w;
    endfunction

    // Load a program at address zero, start it and clock it until it halts or the beat limit runs out.
    task automatic run_program(input logic [4:0] ops [$]);
        int          n;
        int          k;
        int          r;
        logic [15:0] ad;
        n = ops.size();
        // The first word points r2 at the data window.
        send(REQ_WRITE, 16'd0, {2'b00, OP_ADD, COPY_REG, 3'd0, 3'd1, 16'(DATA_LO)});
        for (int i = 0; i < n; i++) send(REQ_WRITE, 16'(i + 1), encode(ops[i], i + 1, n + 1));
        send(REQ_WRITE, 16'(n + 1), {2'b00, OP_HLT, 25'd0});
        send(REQ_START, $urandom, $urandom);
        k = 0;
        while (!(cpu.hseen && cpu.cst == ST_IDLE && !cpu.run) && k < 600) begin
            r = $urandom_range(99);
            ad = $urandom_range(65535, 1024);
            if (r < 5) send(REQ_READ, 16'($urandom_range(DATA_HI, DATA_LO)), $urandom);
            else if (r < 8) send(REQ_WRITE, ad, $urandom);
            else if (r < 10) send(REQ_START, $urandom, $urandom);
            else send(REQ_TICK, $urandom, $urandom);
            k++;
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] e,
                                        input logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %h, got %h", name, e, a);
            errors++;
        end
    endfunction

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (want_q.size() == 0) begin
                $error("result beat with no expectation pending");
                errors++;
            end else begin
                e = want_q.pop_front();
                check_field("rdata", e.rdata, o_out_data.rdata);
                check_field("prog_counter", e.prog_counter, o_out_data.prog_counter);
                check_field("control_state", e.control_state, o_out_data.control_state);
                check_field("copy_busy", e.copy_busy, o_out_data.copy_busy);
                check_field("halted", e.halted, o_out_data.halted);
                check_field("cycles", e.cycles, o_out_data.cycles);
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        if (i_rst_n) i_out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 26);
    end

    // Cycle count and the run limit.
    always @(posedge i_clk) begin
        cyc_n <= cyc_n + 1;
        if (cyc_n > LIMIT) begin
            $display("multicycle_cpu_with_dma_core regression: fail");
            $finish;
        end
    end

    initial begin
        t_row        rows [$];
        t_out        base;
        logic [4:0]  ops [$];
        logic [4:0]  all_ops [$];
        int          len;
        cpu = '{default: '0, rf: '{default: '0}, cst: ST_IDLE, cps: CP_IDLE};
        for (int i = 0; i < 65536; i++) mem_img[i] = '0;
        all_ops = '{OP_ADD, OP_SUB, OP_LSF, OP_RSF, OP_AND, OP_OR, OP_XOR, OP_LHI,
                    OP_LD, OP_ST, OP_JLT, OP_JLE, OP_JEQ, OP_JNE, OP_JIN, OP_CPY,
                    OP_CPO, OP_CPY};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows: idle clock after reset and the address extremes.
        base = '{rdata: 32'd0, prog_counter: 16'd0, control_state: ST_IDLE,
                 copy_busy: 1'b0, halted: 1'b0, cycles: 32'd1};
        rows.push_back('{'{REQ_TICK, 16'h0000, 32'h0}, 1'b1, base});
        rows.push_back('{'{REQ_WRITE, 16'h0000, 32'h0}, 1'b1, base});
        rows.push_back('{'{REQ_WRITE, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, base});
        base.rdata = 32'hFFFF_FFFF;
        rows.push_back('{'{REQ_READ, 16'hFFFF, 32'h0}, 1'b1, base});
        base.rdata = 32'h0;
        rows.push_back('{'{REQ_READ, 16'h0000, 32'hFFFF_FFFF}, 1'b1, base});
        rows.push_back('{'{REQ_WRITE, 16'h5555, 32'hAAAA_AAAA}, 1'b0, base});
        rows.push_back('{'{REQ_READ, 16'h5555, 32'h0}, 1'b0, base});
        rows.push_back('{'{REQ_TICK, 16'hAAAA, 32'h5555_5555}, 1'b0, base});
        foreach (rows[i]) send_beat(rows[i].d, rows[i].typed, rows[i].want);

        // Fill the data window; loads, stores and copies stay inside it.
        for (int a = DATA_LO; a <= DATA_HI; a++) send(REQ_WRITE, a[15:0], $urandom);
        send(REQ_READ, 16'hFFFF, 32'h0);

        // Every defined opcode at least once, plus an undefined one.
        ops = '{OP_LHI, OP_LHI, OP_ADD, OP_SUB, OP_LSF, OP_RSF, OP_AND, OP_OR, OP_XOR,
                OP_LD, OP_ST, OP_JLT, OP_JLE, OP_JEQ, OP_JNE, OP_JIN, OP_CPY, OP_CPO,
                5'd10, OP_CPY, OP_CPO};
        run_program(ops);

        // Random programs: mostly defined opcodes with random fields.
        for (int p = 0; p < 3; p++) begin
            ops.delete();
            len = $urandom_range(6, 3);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(19) == 0) ops.push_back(5'($urandom_range(31)));
                else ops.push_back(all_ops[$urandom_range(all_ops.size() - 1)]);
            end
            run_program(ops);
            send(REQ_READ, 16'($urandom_range(DATA_HI, DATA_LO)), 32'h0);
        end

        i_in_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("multicycle_cpu_with_dma_core regression: pass");
        end else begin
            $display("multicycle_cpu_with_dma_core regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
